### hdl/pcte_pkg.sv
// Shared types and codes for the Pruefer code to tree edge decoder.
// No dependencies; imported by prufer_code_to_tree_edges_unit.
package pcte_pkg;

    localparam int SYM_W  = 6;   // node label / code symbol width
    localparam int NC_W   = 7;   // node count register width
    localparam int OCC_W  = 6;   // occurrence counter width
    localparam int STAT_W = 2;

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [NC_W-1:0]   ncount_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_LENGTH = 2'd1;
    localparam status_t ST_RANGE  = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

endpackage

### hdl/prufer_code_to_tree_edges_unit.sv
// Pruefer code decoder top level: code store, occurrence counters and sequencer.
// Depends on pcte_pkg (types, op and status codes).
// Push: a stored word writes back its count in S_PUSH_WR, busy high for one cycle; an error word follows the accept.
// Decode of L symbols (n = node_count): a stale check of each stored symbol, then for
// each symbol leaf probes as needed, a fetch of it and its count and an edge, and then
// a closing edge to node n-1. Each word is registered from its step, never stalled.
// Reset: async, active low; counters cleared at once through per-node valid bits.

module prufer_code_to_tree_edges_unit #(
    parameter int MAX_NODES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  pcte_pkg::sym_t      code_symbol,
    // configuration write channel (node_count)
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pcte_pkg::ncount_t   cfg_data,
    // result words
    output logic                result_strobe,
    output pcte_pkg::sym_t      edge_leaf,
    output pcte_pkg::sym_t      edge_other,
    output logic                last_edge,
    output pcte_pkg::status_t   status
);

    import pcte_pkg::*;

    // Sizing. Node labels index the counter memory, the store holds n-2 symbols.
    localparam int STORE_DEPTH = MAX_NODES - 2;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PTR_W       = NODE_W + 1;          // pointer may reach n
    localparam ncount_t MAX_N  = NC_W'(MAX_NODES);
    localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(STORE_DEPTH);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUSH_WR  = 4'd1;  // write back incremented count
    localparam logic [3:0] S_CHK_RD   = 4'd2;  // read stored symbol for stale check
    localparam logic [3:0] S_CHK_CMP  = 4'd3;
    localparam logic [3:0] S_LEAF_RD  = 4'd4;  // probe count at pointer
    localparam logic [3:0] S_LEAF_CHK = 4'd5;
    localparam logic [3:0] S_SYM_RD   = 4'd6;  // fetch next code symbol
    localparam logic [3:0] S_CNT_RD   = 4'd7;  // fetch its remaining count
    localparam logic [3:0] S_EMIT     = 4'd8;  // emit edge, decrement count
    localparam logic [3:0] S_FINAL    = 4'd9;  // closing edge to node n-1

    typedef logic [NODE_W-1:0] node_t;

    // Control registers
    logic [3:0]        state_reg,   state_next;
    ncount_t           ncount_reg,  ncount_next;
    logic [CNT_W-1:0]  loaded_reg,  loaded_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic [PTR_W-1:0]  ptr_reg,     ptr_next;
    node_t             leaf_reg,    leaf_next;
    node_t             sym_reg,     sym_next;
    logic [MAX_NODES-1:0] occ_vld_reg, occ_vld_next;
    logic              strobe_reg,  strobe_next;

    // Result payload
    sym_t              leaf_out_reg,  leaf_out_next;
    sym_t              other_out_reg, other_out_next;
    logic              last_out_reg,  last_out_next;
    status_t           stat_out_reg,  stat_out_next;

    // Memories
    sym_t              store_mem [STORE_DEPTH];
    occ_t              occ_mem   [MAX_NODES];
    logic              store_we;
    logic [SA_W-1:0]   store_waddr;
    logic [SA_W-1:0]   store_raddr;
    sym_t              store_rd_reg;
    logic              occ_we;
    node_t             occ_waddr;
    occ_t              occ_wdata;
    node_t             occ_raddr;
    occ_t              occ_rd_reg;
    logic              occ_rvld_reg;

    logic              take;
    logic              dec_bad;
    occ_t              occ_q;
    occ_t              occ_dec;
    ncount_t           n_minus1;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = ~busy;
    assign take      = start & ~busy;

    // A counter whose valid bit is clear reads as zero.
    assign occ_q    = occ_rvld_reg ? occ_rd_reg : '0;
    assign occ_dec  = (occ_q == '0) ? '0 : occ_q - OCC_W'(1);
    assign n_minus1 = ncount_reg - NC_W'(1);

    // Length or node-count fault at decode: loaded must equal n-2, n in 2..MAX.
    assign dec_bad = ((NC_W'(loaded_reg) + NC_W'(2)) != ncount_reg) || (ncount_reg > MAX_N);

    always_comb
    begin
        state_next     = state_reg;
        ncount_next    = ncount_reg;
        loaded_next    = loaded_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        leaf_next      = leaf_reg;
        sym_next       = sym_reg;
        occ_vld_next   = occ_vld_reg;
        strobe_next    = 1'b0;
        leaf_out_next  = leaf_out_reg;
        other_out_next = other_out_reg;
        last_out_next  = last_out_reg;
        stat_out_next  = stat_out_reg;

        store_we    = 1'b0;
        store_waddr = loaded_reg[SA_W-1:0];
        store_raddr = idx_reg[SA_W-1:0];
        occ_we      = 1'b0;
        occ_waddr   = sym_reg;
        occ_wdata   = occ_dec;
        occ_raddr   = sym_reg;

        if (cfg_valid && cfg_ready)
        begin
            ncount_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take && op == OP_PUSH)
                begin
                    if (loaded_reg >= STORE_FULL)
                    begin
                        // full store: drop the symbol
                        strobe_next    = 1'b1;
                        leaf_out_next  = '0;
                        other_out_next = '0;
                        last_out_next  = 1'b1;
                        stat_out_next  = ST_FULL;
                    end
                    else if ((NC_W'(code_symbol) >= ncount_reg) ||
                             (NC_W'(code_symbol) >= MAX_N))
                    begin
                        strobe_next    = 1'b1;
                        leaf_out_next  = '0;
                        other_out_next = '0;
                        last_out_next  = 1'b1;
                        stat_out_next  = ST_RANGE;
                    end
                    else
                    begin
                        // store symbol, fetch its count for the increment
                        store_we    = 1'b1;
                        loaded_next = loaded_reg + CNT_W'(1);
                        sym_next    = code_symbol[NODE_W-1:0];
                        occ_raddr   = code_symbol[NODE_W-1:0];
                        state_next  = S_PUSH_WR;
                    end
                end
                else if (take && op == OP_DECODE)
                begin
                    if (dec_bad)
                    begin
                        strobe_next    = 1'b1;
                        leaf_out_next  = '0;
                        other_out_next = '0;
                        last_out_next  = 1'b1;
                        stat_out_next  = ST_LENGTH;
                        occ_vld_next   = '0;
                        loaded_next    = '0;
                    end
                    else
                    begin
                        idx_next   = '0;
                        ptr_next   = '0;
                        state_next = (loaded_reg == '0) ? S_LEAF_RD : S_CHK_RD;
                    end
                end
            end

            S_PUSH_WR:
            begin
                occ_we                 = 1'b1;
                occ_wdata              = occ_q + OCC_W'(1);
                occ_vld_next[sym_reg]  = 1'b1;
                state_next             = S_IDLE;
            end

            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end

            S_CHK_CMP:
            begin
                // a symbol pushed under a larger node count is now stale
                if (NC_W'(store_rd_reg) >= ncount_reg)
                begin
                    strobe_next    = 1'b1;
                    leaf_out_next  = '0;
                    other_out_next = '0;
                    last_out_next  = 1'b1;
                    stat_out_next  = ST_RANGE;
                    occ_vld_next   = '0;
                    loaded_next    = '0;
                    state_next     = S_IDLE;
                end
                else if ((idx_reg + CNT_W'(1)) == loaded_reg)
                begin
                    idx_next   = '0;
                    ptr_next   = '0;
                    state_next = S_LEAF_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_CHK_RD;
                end
            end

            S_LEAF_RD:
            begin
                if (NC_W'(ptr_reg) >= ncount_reg)
                begin
                    // no leaf left below n: fall back to node n-1
                    ptr_next   = PTR_W'(n_minus1);
                    leaf_next  = NODE_W'(n_minus1);
                    state_next = (idx_reg < loaded_reg) ? S_SYM_RD : S_FINAL;
                end
                else
                begin
                    occ_raddr  = ptr_reg[NODE_W-1:0];
                    state_next = S_LEAF_CHK;
                end
            end

            S_LEAF_CHK:
            begin
                // degree one means no remaining occurrences
                if (occ_q == '0)
                begin
                    leaf_next  = ptr_reg[NODE_W-1:0];
                    state_next = (idx_reg < loaded_reg) ? S_SYM_RD : S_FINAL;
                end
                else
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    state_next = S_LEAF_RD;
                end
            end

            S_SYM_RD:
            begin
                state_next = S_CNT_RD;
            end

            S_CNT_RD:
            begin
                sym_next   = store_rd_reg[NODE_W-1:0];
                occ_raddr  = store_rd_reg[NODE_W-1:0];
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                strobe_next    = 1'b1;
                leaf_out_next  = SYM_W'(leaf_reg);
                other_out_next = SYM_W'(sym_reg);
                last_out_next  = 1'b0;
                stat_out_next  = ST_OK;
                occ_we         = 1'b1;
                idx_next       = idx_reg + CNT_W'(1);
                if ((occ_dec == '0) && (PTR_W'(sym_reg) < ptr_reg))
                begin
                    // symbol just became a leaf behind the pointer: take it now
                    leaf_next  = sym_reg;
                    state_next = (idx_next < loaded_reg) ? S_SYM_RD : S_FINAL;
                end
                else
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    state_next = S_LEAF_RD;
                end
            end

            S_FINAL:
            begin
                strobe_next    = 1'b1;
                leaf_out_next  = SYM_W'(leaf_reg);
                other_out_next = SYM_W'(n_minus1);
                last_out_next  = 1'b1;
                stat_out_next  = ST_OK;
                occ_vld_next   = '0;
                loaded_next    = '0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ncount_reg  <= NC_W'(2);
            loaded_reg  <= '0;
            idx_reg     <= '0;
            ptr_reg     <= '0;
            leaf_reg    <= '0;
            sym_reg     <= '0;
            occ_vld_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ncount_reg  <= ncount_next;
            loaded_reg  <= loaded_next;
            idx_reg     <= idx_next;
            ptr_reg     <= ptr_next;
            leaf_reg    <= leaf_next;
            sym_reg     <= sym_next;
            occ_vld_reg <= occ_vld_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Result payload: no reset, qualified by the strobe
    always_ff @(posedge clk)
    begin
        leaf_out_reg  <= leaf_out_next;
        other_out_reg <= other_out_next;
        last_out_reg  <= last_out_next;
        stat_out_reg  <= stat_out_next;
    end

    // Code store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= code_symbol;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

    // Occurrence counters: one write, one registered read with its valid bit
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        occ_rd_reg   <= occ_mem[occ_raddr];
        occ_rvld_reg <= occ_vld_reg[occ_raddr];
    end

    assign result_strobe = strobe_reg;
    assign edge_leaf     = leaf_out_reg;
    assign edge_other    = other_out_reg;
    assign last_edge     = last_out_reg;
    assign status        = stat_out_reg;

    // Error words carry zero endpoints.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && status != ST_OK) |->
            (last_edge && edge_leaf == '0 && edge_other == '0))
        else $error("error word with non-zero endpoints");

    // A decode with a bad length is answered in the next cycle.
    a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == OP_DECODE && dec_bad) |=>
            (result_strobe && status == ST_LENGTH && !busy))
        else $error("length fault not reported");

    // A finished decode leaves the load cleared.
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_edge && (status == ST_OK || status == ST_LENGTH)) |->
            (loaded_reg == '0 && occ_vld_reg == '0))
        else $error("load not cleared after decode");

    // The leaf pointer never runs past n during a run.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_reg != S_PUSH_WR) |-> (NC_W'(ptr_reg) <= ncount_reg))
        else $error("leaf pointer beyond node count");

endmodule
